// ===== rtl/chm_pkg.sv =====
// ----------------------------------------------------------------------------
// chm_pkg: shared types and constants of the chained hash map
// Request codes, field widths and the command and status records that join
// the controller to the datapath.
// ----------------------------------------------------------------------------
package chm_pkg;

  localparam int KEY_W   = 32;
  localparam int VALUE_W = 32;
  localparam int TYPE_W  = 2;
  localparam int COUNT_W = 6;

  localparam logic [TYPE_W-1:0] REQ_LOOKUP = 2'd0;
  localparam logic [TYPE_W-1:0] REQ_INSERT = 2'd1;
  localparam logic [TYPE_W-1:0] REQ_REMOVE = 2'd2;
  localparam logic [TYPE_W-1:0] REQ_CLEAR  = 2'd3;

  // Memory write operations issued by the controller.
  localparam int WR_W = 3;
  localparam logic [WR_W-1:0] WR_NONE   = 3'd0;
  localparam logic [WR_W-1:0] WR_INIT   = 3'd1;
  localparam logic [WR_W-1:0] WR_VALUE  = 3'd2;
  localparam logic [WR_W-1:0] WR_UNLINK = 3'd3;
  localparam logic [WR_W-1:0] WR_FREE   = 3'd4;
  localparam logic [WR_W-1:0] WR_ALLOC  = 3'd5;
  localparam logic [WR_W-1:0] WR_LINK   = 3'd6;

  typedef struct packed {
    logic            ld_req;
    logic            cur_head;
    logic            cur_link;
    logic            rd_free;
    logic            cap_hit;
    logic            cap_val;
    logic            set_full;
    logic            sweep_start;
    logic            load_out;
    logic [WR_W-1:0] wr;
  } cmd_t;

  typedef struct packed {
    logic              head_nil;
    logic              match;
    logic              link_nil;
    logic              free_nil;
    logic              sweep_last;
    logic [TYPE_W-1:0] req_type;
  } status_t;

endpackage

// ===== rtl/chm_if.sv =====
// ----------------------------------------------------------------------------
// chm_if: request and response channels of the chained hash map
// Valid/ready channels; a beat moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface chm_req_if;
  import chm_pkg::*;
  logic               valid;
  logic               ready;
  logic [TYPE_W-1:0]  req_type;
  logic [KEY_W-1:0]   req_key;
  logic [VALUE_W-1:0] req_value;
  modport source (output valid, req_type, req_key, req_value, input ready);
  modport sink   (input valid, req_type, req_key, req_value, output ready);
endinterface

interface chm_rsp_if;
  import chm_pkg::*;
  logic               valid;
  logic               ready;
  logic               hit;
  logic [VALUE_W-1:0] read_value;
  logic               pool_full;
  logic [COUNT_W-1:0] entry_count;
  modport source (output valid, hit, read_value, pool_full, entry_count, input ready);
  modport sink   (input valid, hit, read_value, pool_full, entry_count, output ready);
endinterface

// ===== rtl/chm_datapath.sv =====
// ----------------------------------------------------------------------------
// chm_datapath: memories and registers of the chained hash map
// Holds bucket heads, node keys, values and links, the free list head, the
// entry count and the response register. Acts on controller commands.
// ----------------------------------------------------------------------------
module chm_datapath #(
  parameter int POOL_SIZE = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  chm_pkg::cmd_t               cmd,
  output chm_pkg::status_t            stat,
  input  logic [chm_pkg::TYPE_W-1:0]  in_type,
  input  logic [chm_pkg::KEY_W-1:0]   in_key,
  input  logic [chm_pkg::VALUE_W-1:0] in_value,
  output logic                        res_hit,
  output logic [chm_pkg::VALUE_W-1:0] res_value,
  output logic                        res_full,
  output logic [chm_pkg::COUNT_W-1:0] res_count
);
  import chm_pkg::*;

  localparam int IDX_W = $clog2(POOL_SIZE);
  localparam int LNK_W = IDX_W + 1;
  localparam int CNT_W = $clog2(POOL_SIZE + 1);
  localparam logic [LNK_W-1:0] NIL = LNK_W'(POOL_SIZE);
  localparam logic [IDX_W-1:0] LAST = IDX_W'(POOL_SIZE - 1);

  logic [LNK_W-1:0]   head_mem [POOL_SIZE];
  logic [KEY_W-1:0]   key_mem  [POOL_SIZE];
  logic [VALUE_W-1:0] val_mem  [POOL_SIZE];
  logic [LNK_W-1:0]   link_mem [POOL_SIZE];

  logic [LNK_W-1:0]   head_rd_r, link_rd_r;
  logic [KEY_W-1:0]   key_rd_r;
  logic [VALUE_W-1:0] val_rd_r;

  logic [TYPE_W-1:0]  type_r;
  logic [KEY_W-1:0]   key_r;
  logic [VALUE_W-1:0] val_r;
  logic [IDX_W-1:0]   bucket_r;
  logic [LNK_W-1:0]   cur_r, cur_nxt, prev_r, prev_nxt, new_r;
  logic [LNK_W-1:0]   free_r, free_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [IDX_W-1:0]   sweep_r, sweep_nxt;
  logic               hit_r, full_r;
  logic [VALUE_W-1:0] found_r;

  logic [IDX_W-1:0]   head_addr, node_addr;
  logic [CNT_W+COUNT_W-1:0] count_ext;

  assign head_addr = cmd.ld_req ? in_key[IDX_W-1:0] : bucket_r;
  assign cur_nxt   = cmd.cur_head ? head_rd_r : (cmd.cur_link ? link_rd_r : cur_r);
  assign prev_nxt  = cmd.cur_head ? NIL : (cmd.cur_link ? cur_r : prev_r);
  assign node_addr = cmd.rd_free ? free_r[IDX_W-1:0] : cur_nxt[IDX_W-1:0];

  always_comb begin
    free_nxt  = free_r;
    count_nxt = count_r;
    sweep_nxt = cmd.sweep_start ? '0 : sweep_r;
    case (cmd.wr)
      WR_INIT: begin
        free_nxt  = '0;
        count_nxt = '0;
        sweep_nxt = sweep_r + 1'b1;
      end
      WR_FREE: begin
        free_nxt  = cur_r;
        count_nxt = count_r - 1'b1;
      end
      WR_ALLOC: free_nxt  = link_rd_r;
      WR_LINK:  count_nxt = count_r + 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      free_r  <= '0;
      count_r <= '0;
      sweep_r <= '0;
    end else begin
      free_r  <= free_nxt;
      count_r <= count_nxt;
      sweep_r <= sweep_nxt;
    end
  end

  // Memory read ports, registered.
  always_ff @(posedge clk) begin
    head_rd_r <= head_mem[head_addr];
    key_rd_r  <= key_mem[node_addr];
    val_rd_r  <= val_mem[node_addr];
    link_rd_r <= link_mem[node_addr];
  end

  // Memory write ports: at most one write per memory per cycle.
  always_ff @(posedge clk) begin
    case (cmd.wr)
      WR_INIT: begin
        head_mem[sweep_r] <= NIL;
        link_mem[sweep_r] <= LNK_W'({1'b0, sweep_r} + 1'b1);
      end
      WR_VALUE: val_mem[cur_r[IDX_W-1:0]] <= val_r;
      WR_UNLINK: begin
        if (prev_r == NIL) begin
          head_mem[bucket_r] <= link_rd_r;
        end else begin
          link_mem[prev_r[IDX_W-1:0]] <= link_rd_r;
        end
      end
      WR_FREE: link_mem[cur_r[IDX_W-1:0]] <= free_r;
      WR_ALLOC: begin
        key_mem[free_r[IDX_W-1:0]]  <= key_r;
        val_mem[free_r[IDX_W-1:0]]  <= val_r;
        link_mem[free_r[IDX_W-1:0]] <= NIL;
      end
      WR_LINK: begin
        if (prev_r == NIL) begin
          head_mem[bucket_r] <= new_r;
        end else begin
          link_mem[prev_r[IDX_W-1:0]] <= new_r;
        end
      end
      default: ;
    endcase
  end

  // Request, walk and result registers.
  always_ff @(posedge clk) begin
    cur_r  <= cur_nxt;
    prev_r <= prev_nxt;
    if (cmd.wr == WR_ALLOC) begin
      new_r <= free_r;
    end
    if (cmd.ld_req) begin
      type_r   <= in_type;
      key_r    <= in_key;
      val_r    <= in_value;
      bucket_r <= in_key[IDX_W-1:0];
      hit_r    <= 1'b0;
      full_r   <= 1'b0;
      found_r  <= '0;
    end else begin
      if (cmd.cap_hit) hit_r <= 1'b1;
      if (cmd.cap_val) found_r <= val_rd_r;
      if (cmd.set_full) full_r <= 1'b1;
    end
    if (cmd.load_out) begin
      res_hit   <= hit_r;
      res_value <= found_r;
      res_full  <= full_r;
      res_count <= count_ext[COUNT_W-1:0];
    end
  end

  assign count_ext = (CNT_W + COUNT_W)'(count_r);

  assign stat.head_nil   = (head_rd_r == NIL);
  assign stat.match      = (key_rd_r == key_r);
  assign stat.link_nil   = (link_rd_r == NIL);
  assign stat.free_nil   = (free_r == NIL);
  assign stat.sweep_last = (sweep_r == LAST);
  assign stat.req_type   = type_r;

endmodule

// ===== rtl/chm_ctrl.sv =====
// ----------------------------------------------------------------------------
// chm_ctrl: request sequencer of the chained hash map
// Walks a bucket chain one node per cycle, issues the memory updates of each
// request, runs the initialization sweep and owns the response valid flag.
// ----------------------------------------------------------------------------
module chm_ctrl (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [chm_pkg::TYPE_W-1:0] in_type,
  output logic                       out_valid,
  input  logic                       out_ready,
  output chm_pkg::cmd_t              cmd,
  input  chm_pkg::status_t           stat
);
  import chm_pkg::*;

  localparam logic [2:0] ST_INIT  = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_HEAD  = 3'd2;
  localparam logic [2:0] ST_CMP   = 3'd3;
  localparam logic [2:0] ST_MISS  = 3'd4;
  localparam logic [2:0] ST_ALLOC = 3'd5;
  localparam logic [2:0] ST_FIN   = 3'd6;
  localparam logic [2:0] ST_DONE  = 3'd7;

  logic [2:0] state_r, state_nxt;
  logic       clr_r, clr_nxt;
  logic       out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    cmd           = '0;
    cmd.wr        = WR_NONE;
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      ST_INIT: begin
        cmd.wr = WR_INIT;
        if (stat.sweep_last) begin
          state_nxt = clr_r ? ST_DONE : ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd.ld_req = 1'b1;
          if (in_type == REQ_CLEAR) begin
            cmd.sweep_start = 1'b1;
            clr_nxt         = 1'b1;
            state_nxt       = ST_INIT;
          end else begin
            clr_nxt   = 1'b0;
            state_nxt = ST_HEAD;
          end
        end
      end
      ST_HEAD: begin
        cmd.cur_head = 1'b1;
        state_nxt    = stat.head_nil ? ST_MISS : ST_CMP;
      end
      ST_CMP: begin
        if (stat.match) begin
          cmd.cap_hit = 1'b1;
          state_nxt   = ST_DONE;
          case (stat.req_type)
            REQ_INSERT: cmd.wr = WR_VALUE;
            REQ_REMOVE: begin
              cmd.cap_val = 1'b1;
              cmd.wr      = WR_UNLINK;
              state_nxt   = ST_FIN;
            end
            default: cmd.cap_val = 1'b1;
          endcase
        end else if (stat.link_nil) begin
          // Step past the tail so that the tail becomes the node to link to.
          cmd.cur_link = 1'b1;
          state_nxt    = ST_MISS;
        end else begin
          cmd.cur_link = 1'b1;
        end
      end
      ST_MISS: begin
        state_nxt = ST_DONE;
        if (stat.req_type == REQ_INSERT) begin
          if (stat.free_nil) begin
            cmd.set_full = 1'b1;
          end else begin
            cmd.rd_free = 1'b1;
            state_nxt   = ST_ALLOC;
          end
        end
      end
      ST_ALLOC: begin
        cmd.wr    = WR_ALLOC;
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        // Second half of a remove or of an insert of a new key.
        cmd.wr    = (stat.req_type == REQ_REMOVE) ? WR_FREE : WR_LINK;
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_INIT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      clr_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== rtl/chained_hash_map_pool.sv =====
// ----------------------------------------------------------------------------
// chained_hash_map_pool: key-to-value map with separate chaining
// A fixed pool of POOL_SIZE nodes and POOL_SIZE buckets; the bucket is the low
// bits of the key. Supports lookup, insert, remove and clear requests.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Fields                                     Beat
//  in_req    sink       req_type, req_key, req_value               one request
//  out_rsp   source     hit, read_value, pool_full, entry_count    one response
//
// A request is accepted in the idle state, then fetches its bucket head and
// compares the chain nodes in turn until a key matches or the chain ends. A
// miss adds a miss step, an insert of a new key adds allocate and link steps,
// a removal adds a free step, and a final step posts the response. Requests
// are taken one at a time. After reset the block sweeps its memories before
// it takes the first request; a clear request runs the same sweep.
// The response register lets a new request start while a response waits;
// a finished request holds until the previous response has been taken.
//
module chained_hash_map_pool #(
  parameter int POOL_SIZE = 32
) (
  input logic     clk,
  input logic     rst_n,
  chm_req_if.sink   in_req,
  chm_rsp_if.source out_rsp
);
  import chm_pkg::*;

  cmd_t    cmd;
  status_t stat;

  // The controller sequences each request; the datapath holds every table.
  chm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_req.valid),
    .in_ready  (in_req.ready),
    .in_type   (in_req.req_type),
    .out_valid (out_rsp.valid),
    .out_ready (out_rsp.ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  chm_datapath #(
    .POOL_SIZE (POOL_SIZE)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .in_type   (in_req.req_type),
    .in_key    (in_req.req_key),
    .in_value  (in_req.req_value),
    .res_hit   (out_rsp.hit),
    .res_value (out_rsp.read_value),
    .res_full  (out_rsp.pool_full),
    .res_count (out_rsp.entry_count)
  );

`ifndef SYNTHESIS
  // One request at a time: an accepted beat closes the input until done.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_req.valid && in_req.ready |=> !in_req.ready)
    else $error("request accepted while another is in flight");

  // Memories are never written while the block waits for a request.
  a_no_idle_write: assert property (@(posedge clk) disable iff (!rst_n)
    in_req.ready |-> cmd.wr == WR_NONE)
    else $error("memory write while idle");

  // A full pool report never comes with a hit or a value.
  a_full_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_rsp.valid && out_rsp.pool_full |-> !out_rsp.hit && out_rsp.read_value == '0)
    else $error("pool full response carries hit or value");
`endif

endmodule

// ===== tb/sv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: self-checking testbench of the chained hash map
// Drives lookup, insert, remove and clear requests through the request
// channel and checks every response, field by field, against a map
// predictor that models the bucket chains and the free-node pool.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import chm_pkg::*;

  localparam int NODES = 32;
  localparam int NIL   = NODES;
  localparam int RANDOM_ITEMS = 930;

  logic clk;
  logic rst_n;

  chm_req_if in_req ();
  chm_rsp_if out_rsp ();

  chained_hash_map_pool #(.POOL_SIZE(NODES)) dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (in_req),
    .out_rsp (out_rsp)
  );

  // One response as it travels through the scoreboard queue.
  typedef struct packed {
    logic               hit;
    logic [VALUE_W-1:0] read_value;
    logic               pool_full;
    logic [COUNT_W-1:0] entry_count;
  } map_rsp_t;

  // A row of the directed table. The flag tells whether the row carries a
  // response that was written in by hand; otherwise the predictor decides.
  typedef struct {
    logic [TYPE_W-1:0]  op;
    logic [KEY_W-1:0]   key;
    logic [VALUE_W-1:0] value;
    bit                 typed;
    map_rsp_t           rsp;
  } map_row_t;

  // Predictor state: bucket heads, node store and free list, with NIL as
  // the empty link just as in the hardware.
  int                 head_of [NODES];
  logic [KEY_W-1:0]   key_of  [NODES];
  logic [VALUE_W-1:0] val_of  [NODES];
  int                 next_of [NODES];
  int                 free_top;
  int                 live_entries;

  map_rsp_t pending_rsp [$];
  int       mismatches;
  int       rsp_seen;
  int       hits_seen;
  int       full_seen;
  bit       idle_on;

  // Clock generator: 2 ns period.
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Safety net: the slowest legal run is well under this, including the
  // memory sweep after reset and after each clear.
  initial begin
    #4000000;
    $display("[chained_hash_map_pool] ERROR");
    $finish;
  end

  // Empty every bucket and chain the free list in index order.
  function automatic void map_wipe();
    for (int i = 0; i < NODES; i++) begin
      head_of[i] = NIL;
      next_of[i] = (i + 1 < NODES) ? i + 1 : NIL;
    end
    free_top = 0;
    live_entries = 0;
  endfunction

  // Apply one request to the predictor and return the response it implies.
  function automatic map_rsp_t map_apply(logic [TYPE_W-1:0] op, logic [KEY_W-1:0] key,
                                         logic [VALUE_W-1:0] value);
    map_rsp_t r;
    int bkt;
    int cur;
    int prv;
    int steps;
    int n;
    r = '0;
    bkt = int'(key % NODES);
    if (op == REQ_CLEAR) begin
      map_wipe();
    end else begin
      cur = head_of[bkt];
      prv = NIL;
      steps = 0;
      // Walk the chain until the key matches or the chain ends.
      while (cur != NIL && steps < NODES && key_of[cur] != key) begin
        prv = cur;
        cur = next_of[cur];
        steps++;
      end
      if (steps >= NODES) cur = NIL;
      r.hit = (cur != NIL);
      case (op)
        REQ_LOOKUP: begin
          if (r.hit) r.read_value = val_of[cur];
        end
        REQ_INSERT: begin
          if (r.hit) begin
            val_of[cur] = value;
          end else if (free_top == NIL) begin
            r.pool_full = 1'b1;
          end else begin
            // Take the free-list head and append it at the chain's tail.
            n = free_top;
            free_top = next_of[n];
            next_of[n] = NIL;
            key_of[n] = key;
            val_of[n] = value;
            if (prv != NIL) next_of[prv] = n;
            else head_of[bkt] = n;
            live_entries++;
          end
        end
        default: begin
          if (r.hit) begin
            r.read_value = val_of[cur];
            if (prv != NIL) next_of[prv] = next_of[cur];
            else head_of[bkt] = next_of[cur];
            next_of[cur] = free_top;
            free_top = cur;
            if (live_entries > 0) live_entries--;
          end
        end
      endcase
    end
    r.entry_count = COUNT_W'(live_entries);
    return r;
  endfunction

  // Present one request beat and hold it until the block accepts it.
  task automatic send_req(logic [TYPE_W-1:0] op, logic [KEY_W-1:0] key,
                          logic [VALUE_W-1:0] value);
    in_req.valid     <= 1'b1;
    in_req.req_type  <= op;
    in_req.req_key   <= key;
    in_req.req_value <= value;
    do @(posedge clk); while (!(in_req.valid && in_req.ready));
  endtask

  // Drop valid after the last beat of a run of requests, or for a gap.
  task automatic drop_req();
    in_req.valid <= 1'b0;
  endtask

  // Push the expected response as the beat goes out, the typed one for a typed
  // row; a typed row is also compared against the predictor, so both must agree.
  task automatic issue(logic [TYPE_W-1:0] op, logic [KEY_W-1:0] key,
                       logic [VALUE_W-1:0] value, bit typed, map_rsp_t typed_rsp);
    map_rsp_t p;
    p = map_apply(op, key, value);
    if (typed && p != typed_rsp) begin
      mismatches++;
      if (mismatches <= 10)
        $display("table row disagrees with predictor: typed %p predicted %p", typed_rsp, p);
    end
    pending_rsp.push_back(typed ? typed_rsp : p);
    send_req(op, key, value);
    if (idle_on && $urandom_range(3) == 0) begin
      drop_req();
      repeat ($urandom_range(16, 1)) @(posedge clk);
    end
  endtask

  // Response side: random stalls on ready, and the check of every beat.
  // Ready is sampled and driven at the rising edge only.
  initial begin
    map_rsp_t want;
    map_rsp_t got;
    out_rsp.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (idle_on && $urandom_range(3) == 0) begin
        out_rsp.ready <= 1'b0;
        repeat ($urandom_range(16, 1)) @(posedge clk);
      end
      out_rsp.ready <= 1'b1;
      @(posedge clk);
      if (out_rsp.valid && out_rsp.ready) begin
        got = '{out_rsp.hit, out_rsp.read_value, out_rsp.pool_full, out_rsp.entry_count};
        rsp_seen++;
        if (got.hit) hits_seen++;
        if (got.pool_full) full_seen++;
        if (pending_rsp.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("response beat with nothing expected: %p", got);
        end else begin
          want = pending_rsp.pop_front();
          if (got != want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("response mismatch: hit %0b/%0b value %h/%h full %0b/%0b count %0d/%0d",
                       want.hit, got.hit, want.read_value, got.read_value,
                       want.pool_full, got.pool_full, want.entry_count, got.entry_count);
          end
        end
      end
    end
  end

  // Stimulus: the directed table first, then random traffic.
  initial begin
    map_row_t rows [$];
    logic [KEY_W-1:0] key_pool [$];
    logic [KEY_W-1:0] k;
    logic [TYPE_W-1:0] op;
    int pick;
    int drain;

    in_req.valid     <= 1'b0;
    in_req.req_type  <= REQ_LOOKUP;
    in_req.req_key   <= '0;
    in_req.req_value <= '0;
    rst_n  = 1'b0;
    idle_on = 1'b1;
    mismatches = 0;
    rsp_seen = 0;
    hits_seen = 0;
    full_seen = 0;
    map_wipe();
    for (int i = 0; i < NODES; i++) begin
      key_of[i] = '0;
      val_of[i] = '0;
    end
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed rows. Typed responses: misses after reset, first inserts,
    // extremes of key and value, a removal of the maximum value, a clear.
    rows.push_back('{REQ_LOOKUP, 32'h0000_0000, 32'h0, 1, '{1'b0, 32'h0, 1'b0, 6'd0}});
    rows.push_back('{REQ_REMOVE, 32'hFFFF_FFFF, 32'h0, 1, '{1'b0, 32'h0, 1'b0, 6'd0}});
    rows.push_back('{REQ_INSERT, 32'h0000_0000, 32'hFFFF_FFFF, 1, '{1'b0, 32'h0, 1'b0, 6'd1}});
    rows.push_back('{REQ_INSERT, 32'hFFFF_FFFF, 32'h0000_0000, 1, '{1'b0, 32'h0, 1'b0, 6'd2}});
    rows.push_back('{REQ_LOOKUP, 32'h0000_0000, 32'h1234_5678, 1,
                     '{1'b1, 32'hFFFF_FFFF, 1'b0, 6'd2}});
    // Same bucket as key 0: chain growth, replace, then unlink mid-chain.
    rows.push_back('{REQ_INSERT, 32'h0000_0020, 32'hAAAA_5555, 0, '0});
    rows.push_back('{REQ_INSERT, 32'h8000_0000, 32'h5555_AAAA, 0, '0});
    rows.push_back('{REQ_INSERT, 32'h0000_0020, 32'h0F0F_0F0F, 1, '{1'b1, 32'h0, 1'b0, 6'd4}});
    rows.push_back('{REQ_REMOVE, 32'h0000_0020, 32'hFFFF_FFFF, 0, '0});
    rows.push_back('{REQ_LOOKUP, 32'h8000_0000, 32'h0, 0, '0});
    rows.push_back('{REQ_REMOVE, 32'h0000_0000, 32'h0, 1, '{1'b1, 32'hFFFF_FFFF, 1'b0, 6'd2}});
    rows.push_back('{REQ_LOOKUP, 32'h0000_0020, 32'h0, 1, '{1'b0, 32'h0, 1'b0, 6'd2}});
    rows.push_back('{REQ_CLEAR,  32'hDEAD_BEEF, 32'hFFFF_FFFF, 1, '{1'b0, 32'h0, 1'b0, 6'd0}});
    rows.push_back('{REQ_LOOKUP, 32'hFFFF_FFFF, 32'h0, 1, '{1'b0, 32'h0, 1'b0, 6'd0}});
    foreach (rows[i]) issue(rows[i].op, rows[i].key, rows[i].value, rows[i].typed, rows[i].rsp);

    // Fill the pool completely, then hit the exhausted case: a new key is
    // refused, a present key is still replaced, and a remove frees a node.
    for (int i = 0; i < NODES; i++) issue(REQ_INSERT, 32'(i * 7 + 3), $urandom(), 0, '0);
    issue(REQ_INSERT, 32'hFFFF_FFF0, 32'h1, 1, '{1'b0, 32'h0, 1'b1, 6'd32});
    issue(REQ_INSERT, 32'd3, 32'hCAFE_F00D, 0, '0);
    issue(REQ_REMOVE, 32'd10, 32'h0, 0, '0);
    issue(REQ_INSERT, 32'hFFFF_FFF0, 32'h2, 0, '0);
    issue(REQ_CLEAR, 32'h0, 32'h0, 0, '0);

    // Random part: keys drawn mostly from a small recycled set so that
    // lookups and removes hit, chains collide and the pool runs dry at times.
    for (int i = 0; i < 24; i++)
      key_pool.push_back($urandom_range(1) ? $urandom() : 32'($urandom_range(7)) << 5
                         | 32'($urandom_range(3)));
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS - 120) idle_on = 1'b0;
      pick = $urandom_range(99);
      if (pick < 44) op = REQ_INSERT;
      else if (pick < 72) op = REQ_LOOKUP;
      else if (pick < 98) op = REQ_REMOVE;
      else op = REQ_CLEAR;
      if ($urandom_range(9) < 8) k = key_pool[$urandom_range(key_pool.size() - 1)];
      else k = $urandom();
      // Occasionally refresh the key set so new keys keep appearing.
      if ($urandom_range(15) == 0) key_pool[$urandom_range(key_pool.size() - 1)] = $urandom();
      issue(op, k, $urandom(), 0, '0);
    end
    drop_req();

    // Drain: wait for every expected response, then a short settle.
    drain = 0;
    while (pending_rsp.size() != 0 && drain < 20000) begin
      @(posedge clk);
      drain++;
    end
    repeat (64) @(posedge clk);

    $display("Covered %0d responses (%0d hits, %0d pool-full refusals) over directed",
             rsp_seen, hits_seen, full_seen);
    $display("rows, a full-pool fill and random traffic with idle bursts on both sides.");
    if (mismatches == 0 && pending_rsp.size() == 0) begin
      $display("[chained_hash_map_pool] OK");
    end else begin
      $display("%0d mismatches, %0d responses missing", mismatches, pending_rsp.size());
      $display("[chained_hash_map_pool] ERROR");
    end
    $finish;
  end

endmodule
